// File: rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// shared types, constants and the paeth predictor for the scanline unfilter
// ----------------------------------------------------------------------------
package psu_pkg;

	localparam int MAX_ROW_BYTES_DEF = 4096;

	localparam int BYTE_W       = 8;
	localparam int ROW_BYTES_W  = 13;
	localparam int IMAGE_ROWS_W = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int FILTER_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_BYTES  = 1'b0,
		REG_IMAGE_ROWS = 1'b1
	} cfg_reg_t;

	typedef enum logic [FILTER_W-1:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	localparam logic [BYTE_W-1:0] FILTER_TYPE_MAX = 8'd4;

	// context of one data word between control and reconstruction
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last_col;
		logic              last_row;
		logic              row_nz;
		logic              col_nz;
		filter_t           filter;
		logic              flagged;
	} ctx_t;

	function automatic logic [9:0] abs_diff(input logic signed [10:0] d);
		logic signed [10:0] m;
		begin
			m = (d < 0) ? -d : d;
			return m[9:0];
		end
	endfunction

	// nearest of left, above, upper-left; ties to left, then above
	function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] c);
		logic signed [10:0] sa;
		logic signed [10:0] sb;
		logic signed [10:0] sc;
		logic [9:0]         pa;
		logic [9:0]         pb;
		logic [9:0]         pc;
		begin
			sa = 11'(signed'({1'b0, a}));
			sb = 11'(signed'({1'b0, b}));
			sc = 11'(signed'({1'b0, c}));
			pa = abs_diff(sb - sc);
			pb = abs_diff(sa - sc);
			pc = abs_diff(sa + sb - 11'sd2 * sc);
			if (pa <= pb && pa <= pc) begin
				return a;
			end else if (pb <= pc) begin
				return b;
			end else begin
				return c;
			end
		end
	endfunction

endpackage

// File: rtl/psu_if.sv
// ----------------------------------------------------------------------------
// psu_if
// stream, result and configuration channels of the scanline unfilter
// ----------------------------------------------------------------------------
interface psu_in_if;
	logic                    valid;
	logic                    ready;
	logic [psu_pkg::BYTE_W-1:0] stream_byte;

	modport source(output valid, output stream_byte, input ready);
	modport sink(input valid, input stream_byte, output ready);
endinterface

interface psu_out_if;
	logic                    valid;
	logic                    ready;
	logic [psu_pkg::BYTE_W-1:0] pixel;
	logic                    row_end;
	logic                    image_end;
	logic                    bad_filter;

	modport source(output valid, output pixel, output row_end, output image_end,
		output bad_filter, input ready);
	modport sink(input valid, input pixel, input row_end, input image_end,
		input bad_filter, output ready);
endinterface

interface psu_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [psu_pkg::CFG_IDX_W-1:0]  index;
	logic [psu_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/psu_line_buf.sv
// ----------------------------------------------------------------------------
// psu_line_buf
// line store of the previous row, one write and one registered read port
// ----------------------------------------------------------------------------
module psu_line_buf #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
	parameter int AW            = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [psu_pkg::BYTE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [psu_pkg::BYTE_W-1:0] rd_data
);
	import psu_pkg::*;

	logic [BYTE_W-1:0] mem [MAX_ROW_BYTES];
	logic [BYTE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/psu_ctrl.sv
// ----------------------------------------------------------------------------
// psu_ctrl
// configuration registers, row and column tracking, input register stage
// ----------------------------------------------------------------------------
module psu_ctrl #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
	parameter int AW            = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	psu_in_if.sink          stream,
	psu_cfg_if.sink         cfg,
	input  logic            s1_go,
	output logic            s1_valid,
	output psu_pkg::ctx_t   ctx_s1,
	output logic [AW-1:0]   col_s1,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr
);
	import psu_pkg::*;

	localparam logic [16:0] MAX_L = 17'(MAX_ROW_BYTES);

	logic [ROW_BYTES_W-1:0]  row_bytes_q;
	logic [IMAGE_ROWS_W-1:0] image_rows_q;
	logic [AW-1:0]           column_q;
	logic [IMAGE_ROWS_W-1:0] row_q;
	logic                    awaiting_q;
	filter_t                 filter_q;
	logic                    flagged_q;
	logic                    s1_valid_q;
	ctx_t                    ctx_q_s1;
	logic [AW-1:0]           col_q_s1;

	logic        accept;
	logic        data_acc;
	logic [16:0] len;
	logic [16:0] rows;
	logic        last_col;
	logic        last_row;

	assign cfg.ready    = 1'b1;
	assign stream.ready = !s1_valid_q || s1_go;
	assign accept       = stream.valid && stream.ready;
	assign data_acc     = accept && !awaiting_q;

	always_comb begin
		len = 17'(row_bytes_q);
		if (len == 17'd0) begin
			len = 17'd1;
		end
		if (len > MAX_L) begin
			len = MAX_L;
		end
		rows = 17'(image_rows_q);
		if (rows == 17'd0) begin
			rows = 17'd1;
		end
		last_col = (17'(column_q) + 17'd1) >= len;
		last_row = (17'(row_q) + 17'd1) >= rows;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= ROW_BYTES_W'(1);
			image_rows_q <= IMAGE_ROWS_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_ROW_BYTES:  row_bytes_q  <= cfg.data[ROW_BYTES_W-1:0];
				REG_IMAGE_ROWS: image_rows_q <= cfg.data[IMAGE_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			row_q      <= '0;
			awaiting_q <= 1'b1;
			filter_q   <= FLT_NONE;
			flagged_q  <= 1'b0;
		end else if (accept) begin
			if (awaiting_q) begin
				if (stream.stream_byte > FILTER_TYPE_MAX) begin
					filter_q  <= FLT_NONE;
					flagged_q <= 1'b1;
				end else begin
					filter_q  <= filter_t'(stream.stream_byte[FILTER_W-1:0]);
					flagged_q <= 1'b0;
				end
				column_q   <= '0;
				awaiting_q <= 1'b0;
			end else if (last_col) begin
				column_q   <= '0;
				awaiting_q <= 1'b1;
				row_q      <= last_row ? '0 : row_q + IMAGE_ROWS_W'(1);
			end else begin
				column_q <= column_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (data_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			ctx_q_s1.data     <= stream.stream_byte;
			ctx_q_s1.last_col <= last_col;
			ctx_q_s1.last_row <= last_row;
			ctx_q_s1.row_nz   <= (row_q != '0);
			ctx_q_s1.col_nz   <= (column_q != '0);
			ctx_q_s1.filter   <= filter_q;
			ctx_q_s1.flagged  <= flagged_q;
			col_q_s1          <= column_q;
		end
	end

	assign s1_valid = s1_valid_q;
	assign ctx_s1   = ctx_q_s1;
	assign col_s1   = col_q_s1;
	assign rd_en    = data_acc;
	assign rd_addr  = column_q;

endmodule

// File: rtl/psu_recon.sv
// ----------------------------------------------------------------------------
// psu_recon
// filter reversal from left, above and upper-left bytes, result register
// ----------------------------------------------------------------------------
module psu_recon #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
	parameter int AW            = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s1_valid,
	input  psu_pkg::ctx_t              ctx_s1,
	input  logic [AW-1:0]              col_s1,
	input  logic [psu_pkg::BYTE_W-1:0] above,
	output logic                       s1_go,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [psu_pkg::BYTE_W-1:0] wr_data,
	psu_out_if.source                  result
);
	import psu_pkg::*;

	logic [BYTE_W-1:0] left_q;
	logic [BYTE_W-1:0] upleft_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] pixel_q;
	logic              row_end_q;
	logic              image_end_q;
	logic              bad_filter_q;

	logic [BYTE_W-1:0] a;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] c;
	logic [BYTE_W:0]   avg_sum;
	logic [BYTE_W-1:0] pred;
	logic [BYTE_W-1:0] pix;

	assign s1_go = s1_valid && (!out_valid_q || result.ready);

	always_comb begin
		a       = ctx_s1.col_nz ? left_q : '0;
		b       = ctx_s1.row_nz ? above : '0;
		c       = (ctx_s1.row_nz && ctx_s1.col_nz) ? upleft_q : '0;
		avg_sum = {1'b0, a} + {1'b0, b};
		case (ctx_s1.filter)
			FLT_SUB:   pred = a;
			FLT_UP:    pred = b;
			FLT_AVG:   pred = avg_sum[BYTE_W:1];
			FLT_PAETH: pred = paeth(a, b, c);
			default:   pred = '0;
		endcase
		pix = ctx_s1.data + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_go) begin
			left_q   <= pix;
			upleft_q <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			pixel_q      <= pix;
			row_end_q    <= ctx_s1.last_col;
			image_end_q  <= ctx_s1.last_col && ctx_s1.last_row;
			bad_filter_q <= ctx_s1.flagged;
		end
	end

	assign wr_en   = s1_go;
	assign wr_addr = col_s1;
	assign wr_data = pix;

	assign result.valid      = out_valid_q;
	assign result.pixel      = pixel_q;
	assign result.row_end    = row_end_q;
	assign result.image_end  = image_end_q;
	assign result.bad_filter = bad_filter_q;

endmodule

// File: rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Undoes the PNG None, Sub, Up, Average and Paeth filters on an 8-bit,
// one-byte-per-pixel stream. Each row is a filter-type word followed by
// row_bytes pixel words; the type word gives no result, each pixel word gives
// one reconstructed pixel marked with row end, image end and a bad-filter flag
// for rows whose type was above 4 (decoded as None). The block takes one word
// per cycle unless the result side stalls it. Each pixel word is captured in
// the input register stage together with its line store read, and is then
// reconstructed into the result register. The previous row lives in a
// single-port-write, single-port-read store of MAX_ROW_BYTES bytes with no
// clearing pass after reset. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	psu_in_if.sink    stream,
	psu_out_if.source result,
	psu_cfg_if.sink   cfg
);
	import psu_pkg::*;

	localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

	logic              s1_go;
	logic              s1_valid;
	ctx_t              ctx_s1;
	logic [AW-1:0]     col_s1;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;

	psu_ctrl #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.AW            (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.cfg      (cfg),
		.s1_go    (s1_go),
		.s1_valid (s1_valid),
		.ctx_s1   (ctx_s1),
		.col_s1   (col_s1),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr)
	);

	psu_line_buf #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.AW            (AW)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psu_recon #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES),
		.AW            (AW)
	) u_recon (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.ctx_s1   (ctx_s1),
		.col_s1   (col_s1),
		.above    (rd_data),
		.s1_go    (s1_go),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.result   (result)
	);

endmodule

// File: sim/png_scanline_unfilter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_tb
// Streams filtered PNG rows into the unfilter with random gaps on both the
// stream and the result side. Each reconstructed pixel and its row end,
// image end and bad filter marks are checked against a behavioral model of
// the reconstruction. Directed rows cover every filter type and bad types.
// Further phases then sweep row length and row count, with zero settings and
// the largest row count included.
module png_scanline_unfilter_tb;
	import psu_pkg::*;

	localparam int unsigned LINE_MAX   = MAX_ROW_BYTES_DEF;
	localparam int unsigned LONG_STALL = 400;

	typedef struct packed {
		logic [BYTE_W-1:0] pixel;
		logic              row_end;
		logic              image_end;
		logic              bad_filter;
	} pixel_word_t;

	logic clk;
	logic arst_n;

	psu_in_if  stream_ch();
	psu_out_if result_ch();
	psu_cfg_if cfg_ch();

	png_scanline_unfilter dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// reconstruction state
	logic [BYTE_W-1:0]       prev_line [LINE_MAX];
	logic [ROW_BYTES_W-1:0]  row_len_reg    = 13'd1;
	logic [IMAGE_ROWS_W-1:0] row_cnt_reg    = 16'd1;
	int unsigned             cur_col        = 0;
	int unsigned             cur_row        = 0;
	bit                      want_type      = 1'b1;
	filter_t                 cur_filter     = FLT_NONE;
	logic [BYTE_W-1:0]       left_pix       = '0;
	logic [BYTE_W-1:0]       above_left_pix = '0;
	bit                      cur_bad        = 1'b0;
	int unsigned             line_fill      = 0;

	// stream generator position
	bit          gen_await = 1'b1;
	int unsigned gen_col   = 0;
	int unsigned gen_row   = 0;

	logic [BYTE_W-1:0] stream_words [$];
	pixel_word_t       pending_pixels [$];
	int unsigned       words_queued = 0;
	int unsigned       pixels_seen  = 0;
	int unsigned       pixel_errors = 0;

	int unsigned send_wait = 0;
	int unsigned send_calm = 0;
	int unsigned recv_hold = 0;
	int unsigned recv_calm = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 999);
		if (r < 5) begin
			calm = $urandom_range(40, 200);
			return 0;
		end
		if (r < 600) return 0;
		if (r < 900) return $urandom_range(1, 3);
		if (r < 985) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned eff_len(logic [ROW_BYTES_W-1:0] v);
		if (v == 0) return 1;
		if (v > LINE_MAX) return LINE_MAX;
		return v;
	endfunction

	function automatic int unsigned eff_rows(logic [IMAGE_ROWS_W-1:0] v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic logic [BYTE_W-1:0] paeth_pick(logic [BYTE_W-1:0] a,
		logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] c);
		int ia;
		int ib;
		int ic;
		int p;
		int da;
		int db;
		int dc;
		ia = a;
		ib = b;
		ic = c;
		p  = ia + ib - ic;
		da = (p > ia) ? p - ia : ia - p;
		db = (p > ib) ? p - ib : ib - p;
		dc = (p > ic) ? p - ic : ic - p;
		if (da <= db && da <= dc) return a;
		if (db <= dc) return b;
		return c;
	endfunction

	task automatic unfilter_word(input logic [BYTE_W-1:0] x);
		int unsigned       len;
		int unsigned       rows;
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] pred;
		pixel_word_t       px;
		len  = eff_len(row_len_reg);
		rows = eff_rows(row_cnt_reg);
		if (want_type) begin
			if (x > FILTER_TYPE_MAX) begin
				cur_filter = FLT_NONE;
				cur_bad    = 1'b1;
			end else begin
				cur_filter = filter_t'(x[FILTER_W-1:0]);
				cur_bad    = 1'b0;
			end
			cur_col        = 0;
			left_pix       = '0;
			above_left_pix = '0;
			want_type      = 1'b0;
			return;
		end
		a = left_pix;
		b = (cur_row != 0) ? prev_line[cur_col] : '0;
		c = (cur_row != 0 && cur_col != 0) ? above_left_pix : '0;
		case (cur_filter)
			FLT_SUB:   pred = a;
			FLT_UP:    pred = b;
			FLT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
			FLT_PAETH: pred = paeth_pick(a, b, c);
			default:   pred = '0;
		endcase
		px.pixel              = x + pred;
		prev_line[cur_col]    = px.pixel;
		left_pix              = px.pixel;
		above_left_pix        = b;
		if (cur_col + 1 > line_fill) line_fill = cur_col + 1;
		px.row_end    = (cur_col + 1 >= len);
		px.image_end  = px.row_end && (cur_row + 1 >= rows);
		px.bad_filter = cur_bad;
		pending_pixels.push_back(px);
		if (px.row_end) begin
			cur_col   = 0;
			want_type = 1'b1;
			cur_row   = (cur_row + 1 >= rows) ? 0 : cur_row + 1;
		end else begin
			cur_col++;
		end
	endtask

	function automatic void compare_field(string field, logic [BYTE_W-1:0] want,
		logic [BYTE_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %02h, got %02h", $time, field, want, got);
			pixel_errors++;
		end
	endfunction

	task automatic check_pixel(input pixel_word_t got);
		pixel_word_t want;
		if (pending_pixels.size() == 0) begin
			$display("%0t ns: pixel %02h with none expected", $time, got.pixel);
			pixel_errors++;
			return;
		end
		want = pending_pixels.pop_front();
		compare_field("pixel", want.pixel, got.pixel);
		compare_field("row_end", 8'(want.row_end), 8'(got.row_end));
		compare_field("image_end", 8'(want.image_end), 8'(got.image_end));
		compare_field("bad_filter", 8'(want.bad_filter), 8'(got.bad_filter));
	endtask

	// stream driver
	always @(posedge clk) begin
		if (!arst_n) begin
			stream_ch.valid       <= 1'b0;
			stream_ch.stream_byte <= '0;
		end else begin
			if (stream_ch.valid && stream_ch.ready) unfilter_word(stream_ch.stream_byte);
			if (!stream_ch.valid || stream_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					stream_ch.valid <= 1'b0;
				end else if (stream_words.size() > 0) begin
					stream_ch.valid       <= 1'b1;
					stream_ch.stream_byte <= stream_words.pop_front();
					send_wait = pick_gap(send_calm);
				end else begin
					stream_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				check_pixel({result_ch.pixel, result_ch.row_end, result_ch.image_end,
					result_ch.bad_filter});
				pixels_seen++;
				if (pixels_seen % 4000 == 1000) recv_hold = LONG_STALL;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				recv_hold = pick_gap(recv_calm);
			end
		end
	end

	task automatic push_word();
		logic [BYTE_W-1:0] w;
		int unsigned       r;
		r = $urandom_range(0, 99);
		if (gen_await) begin
			if (r < 8) w = 8'($urandom_range(FILTER_TYPE_MAX + 1, 255));
			else w = 8'($urandom_range(0, FILTER_TYPE_MAX));
			gen_await = 1'b0;
			gen_col   = 0;
		end else begin
			w = (r < 4) ? 8'h00 : (r < 8) ? 8'hFF : 8'($urandom);
			if (gen_col + 1 >= eff_len(row_len_reg)) begin
				gen_col   = 0;
				gen_await = 1'b1;
				gen_row   = (gen_row + 1 >= eff_rows(row_cnt_reg)) ? 0 : gen_row + 1;
			end else begin
				gen_col++;
			end
		end
		stream_words.push_back(w);
		words_queued++;
	endtask

	task automatic finish_image();
		gen_await = want_type;
		gen_col   = cur_col;
		gen_row   = cur_row;
		while (!(gen_await && gen_row == 0)) push_word();
	endtask

	task automatic settle();
		do @(negedge clk);
		while (stream_words.size() != 0 || stream_ch.valid || pending_pixels.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_ROW_BYTES) row_len_reg = val[ROW_BYTES_W-1:0];
		else row_cnt_reg = val;
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] len_val,
		logic [CFG_DATA_W-1:0] rows_val, int unsigned n, bit whole);
		settle();
		// longer rows mid-image would read line store entries never written
		if (cur_row != 0 && eff_len(len_val[ROW_BYTES_W-1:0]) > line_fill) begin
			finish_image();
			settle();
		end
		write_reg(REG_ROW_BYTES, len_val);
		write_reg(REG_IMAGE_ROWS, rows_val);
		cfg_ch.valid <= 1'b0;
		gen_await = want_type;
		gen_col   = cur_col;
		gen_row   = cur_row;
		repeat (n) push_word();
		if (whole) finish_image();
	endtask

	initial begin
		int unsigned           random_goal;
		int unsigned           r;
		logic [CFG_DATA_W-1:0] len_val;
		logic [CFG_DATA_W-1:0] rows_val;
		arst_n                = 1'b0;
		stream_ch.valid       = 1'b0;
		stream_ch.stream_byte = '0;
		result_ch.ready       = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = REG_ROW_BYTES;
		cfg_ch.data           = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-pixel rows at reset settings, then Sub, Up, Average, Paeth and a bad type over 2x3 images
		stream_words = '{8'(FLT_NONE), 8'h00, FILTER_TYPE_MAX + 8'd1, 8'hFF};
		settle();
		write_reg(REG_ROW_BYTES, 16'd2);
		write_reg(REG_IMAGE_ROWS, 16'd3);
		cfg_ch.valid <= 1'b0;
		stream_words = '{8'(FLT_SUB), 8'hFF, 8'h01, 8'(FLT_UP), 8'h80, 8'hFF,
			8'(FLT_AVG), 8'hFF, 8'hFF, 8'(FLT_PAETH), 8'h00, 8'h7F,
			8'(FLT_PAETH), 8'hFF, 8'h80, 8'hFF, 8'h55, 8'hAA};

		// row count extremes and zero settings
		run_phase(16'd1, 16'hFFFF, 300, 1'b0);
		run_phase(16'd0, 16'd0, 100, 1'b1);

		random_goal = 2000;
		while (words_queued < random_goal) begin
			r = $urandom_range(0, 99);
			if (r < 5) len_val = 16'd0;
			else if (r < 10) len_val = 16'hE000 | 16'($urandom_range(1, 8));
			else if (r < 80) len_val = 16'($urandom_range(1, 12));
			else len_val = 16'($urandom_range(13, 80));
			rows_val = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
			run_phase(len_val, rows_val, $urandom_range(40, 160), 1'($urandom_range(0, 1)));
		end

		settle();
		if (pixel_errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
